### hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types, register indexes, reset values and helpers of the speech
// segment tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned FrameW   = 5;
	localparam int unsigned TimeW    = 16;

	localparam logic [CfgIdxW-1:0] REG_FRAME_TIME = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_TIME   = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MIN_TIME   = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_HANGOVER   = 2'd3;

	localparam logic [FrameW-1:0] FRAME_TIME_RST = 5'd20;
	localparam logic [TimeW-1:0]  MAX_TIME_RST   = 16'd5000;
	localparam logic [TimeW-1:0]  MIN_TIME_RST   = 16'd300;
	localparam logic [TimeW-1:0]  HANGOVER_RST   = 16'd100;

	typedef struct packed {
		logic [FrameW-1:0] frame_ms;
		logic [TimeW-1:0]  max_ms;
		logic [TimeW-1:0]  min_time;
		logic [TimeW-1:0]  hangover;
	} cfg_t;

	typedef struct packed {
		logic              speaking;
		logic              over_pending;
		logic              busy;
		logic [TimeW-1:0]  segment_time;
		logic [TimeW-1:0]  silence_time;
	} state_t;

	function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
			input logic [FrameW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {{(TimeW + 1 - FrameW){1'b0}}, b};
		return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/sst_cfg_regs.sv
// ----------------------------------------------------------------------------
// sst_cfg_regs
// Configuration register file: frame time, maximum and minimum segment
// duration and hangover time.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [sst_pkg::CfgIdxW-1:0]   wr_index,
	input  wire logic [sst_pkg::CfgDataW-1:0]  wr_data,
	output sst_pkg::cfg_t                      cfg
);

	sst_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_ms <= sst_pkg::FRAME_TIME_RST;
			cfg_q.max_ms   <= sst_pkg::MAX_TIME_RST;
			cfg_q.min_time <= sst_pkg::MIN_TIME_RST;
			cfg_q.hangover <= sst_pkg::HANGOVER_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				sst_pkg::REG_FRAME_TIME: cfg_q.frame_ms <= wr_data[sst_pkg::FrameW-1:0];
				sst_pkg::REG_MAX_TIME:   cfg_q.max_ms   <= wr_data;
				sst_pkg::REG_MIN_TIME:   cfg_q.min_time <= wr_data;
				sst_pkg::REG_HANGOVER:   cfg_q.hangover <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/speech_segment_tracker_core.sv
// ----------------------------------------------------------------------------
// speech_segment_tracker_core
// Turns per-frame voice activity decisions into speech segment events.
// ----------------------------------------------------------------------------
// One frame word can be accepted per clock cycle unless the input stalls.
// A word is held in an input register, then compare and saturating add logic
// updates the segment state and writes any event word to the result register.
// A frame that causes no event leaves no output word. A frame leaves the input
// register only when the result register is empty or being emptied, so the
// input stalls while an untaken result word is held and a frame waits behind
// it, whether or not that frame causes an event. Configuration writes are taken
// at any time but are meant for idle periods only.
`default_nettype none

module speech_segment_tracker_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [sst_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [sst_pkg::CfgDataW-1:0]  cfg_data,
	input  wire logic                          in_valid,
	output      logic                          in_ready,
	input  wire logic                          voice_active,
	input  wire logic                          consumer_done,
	output      logic                          out_valid,
	input  wire logic                          out_ready,
	output      logic                          voice_start,
	output      logic                          voice_frame,
	output      logic                          voice_stop,
	output      logic                          voice_over,
	output      logic                          voice_drop,
	output      logic [sst_pkg::TimeW-1:0]     duration_ms
);

	sst_pkg::cfg_t   cfg;
	sst_pkg::state_t state_q;
	sst_pkg::state_t state_nx;

	logic                      item_valid_s1;
	logic                      act_s1;
	logic                      done_s1;
	logic                      fire;
	logic                      emit;
	logic                      ev_start;
	logic                      ev_stop;
	logic                      ev_over;
	logic                      ev_drop;
	logic [sst_pkg::TimeW-1:0] seg_add;

	logic                      out_valid_q;
	logic                      voice_start_q;
	logic                      voice_stop_q;
	logic                      voice_over_q;
	logic                      voice_drop_q;
	logic [sst_pkg::TimeW-1:0] duration_q;

	assign cfg_ready = 1'b1;

	sst_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign fire     = item_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !item_valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1  <= voice_active;
			done_s1 <= consumer_done;
		end
	end

	assign seg_add = sst_pkg::sat_add(state_q.segment_time, cfg.frame_ms);

	always_comb begin
		state_nx = state_q;
		emit     = 1'b0;
		ev_start = 1'b0;
		ev_stop  = 1'b0;
		ev_over  = 1'b0;
		ev_drop  = 1'b0;
		if (!state_q.busy || done_s1) begin
			state_nx.busy = 1'b0;
			if (!(state_q.over_pending && act_s1)) begin
				state_nx.over_pending = 1'b0;
				if (state_q.speaking != act_s1) begin
					if (act_s1) begin
						state_nx.segment_time = {{(sst_pkg::TimeW - sst_pkg::FrameW){1'b0}},
							cfg.frame_ms};
						state_nx.speaking = 1'b1;
						ev_start = 1'b1;
						emit = 1'b1;
					end else if (state_q.silence_time >= cfg.hangover) begin
						state_nx.segment_time = seg_add;
						state_nx.speaking = 1'b0;
						ev_stop = 1'b1;
						ev_drop = seg_add < cfg.min_time;
						emit = 1'b1;
					end
				end else if (state_q.speaking) begin
					state_nx.segment_time = seg_add;
					if (seg_add >= cfg.max_ms) begin
						ev_stop = 1'b1;
						ev_over = 1'b1;
						state_nx.speaking = 1'b0;
						state_nx.over_pending = 1'b1;
					end
					emit = 1'b1;
				end
				state_nx.silence_time = act_s1 ? '0 :
					sst_pkg::sat_add(state_q.silence_time, cfg.frame_ms);
				if (emit) begin
					state_nx.busy = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			state_q     <= state_nx;
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			voice_start_q <= ev_start;
			voice_stop_q  <= ev_stop;
			voice_over_q  <= ev_over;
			voice_drop_q  <= ev_drop;
			duration_q    <= state_nx.segment_time;
		end
	end

	assign out_valid   = out_valid_q;
	assign voice_start = voice_start_q;
	assign voice_frame = 1'b1;
	assign voice_stop  = voice_stop_q;
	assign voice_over  = voice_over_q;
	assign voice_drop  = voice_drop_q;
	assign duration_ms = duration_q;

endmodule

`default_nettype wire

### hw/rtl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level assertions on the speech segment tracker event words.
// ----------------------------------------------------------------------------
`default_nettype none

module sst_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic                      voice_start,
	input wire logic                      voice_frame,
	input wire logic                      voice_stop,
	input wire logic                      voice_over,
	input wire logic                      voice_drop,
	input wire logic [sst_pkg::TimeW-1:0] duration_ms
);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(duration_ms)
			&& $stable(voice_stop) && $stable(voice_start))
		else $error("stalled event word changed");

	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> voice_frame)
		else $error("event word without frame flag");

	a_over: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && voice_over |-> voice_stop && !voice_drop && !voice_start)
		else $error("over event is not a plain stop");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && voice_start |-> !voice_stop && !voice_drop)
		else $error("start event carries stop flags");

endmodule

bind speech_segment_tracker_core sst_checker u_sst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.voice_start (voice_start),
	.voice_frame (voice_frame),
	.voice_stop  (voice_stop),
	.voice_over  (voice_over),
	.voice_drop  (voice_drop),
	.duration_ms (duration_ms)
);

`default_nettype wire

### tb/sv/speech_segment_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// speech_segment_tracker_core_tb
// Drives frame words through the speech segment tracker with random gaps and
// random receiver stalls, tracks the expected segment events in a software
// model of the segment state, and compares every result word field by field.
// A directed opening covers start, plain frame, hangover, drop, over and the
// busy discard, then random speech bursts run under several register
// settings, including zero frame time and long unbroken speech and silence.
// ----------------------------------------------------------------------------
`default_nettype none

module speech_segment_tracker_core_tb;

	import sst_pkg::*;

	typedef struct packed {
		logic act;
		logic done;
	} frame_word_t;

	typedef struct packed {
		logic             start;
		logic             frame;
		logic             stop;
		logic             over;
		logic             drop;
		logic [TimeW-1:0] dur;
	} seg_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                voice_active = 1'b0;
	logic                consumer_done = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic                voice_start;
	logic                voice_frame;
	logic                voice_stop;
	logic                voice_over;
	logic                voice_drop;
	logic [TimeW-1:0]    duration_ms;

	frame_word_t pending_frames[$];
	seg_event_t  awaited_events[$];

	cfg_t   shadow_cfg = '{FRAME_TIME_RST, MAX_TIME_RST, MIN_TIME_RST, HANGOVER_RST};
	state_t trk = '0;

	int mismatch_count = 0;
	int frames_taken = 0;
	bit idle_on = 1'b1;
	bit hold_used = 1'b0;
	int hold_left = 0;

	speech_segment_tracker_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.voice_active  (voice_active),
		.consumer_done (consumer_done),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.voice_start   (voice_start),
		.voice_frame   (voice_frame),
		.voice_stop    (voice_stop),
		.voice_over    (voice_over),
		.voice_drop    (voice_drop),
		.duration_ms   (duration_ms)
	);

	always #5 clk = ~clk;

	function automatic logic [TimeW-1:0] sat_ms(input logic [TimeW-1:0] a,
			input logic [FrameW-1:0] b);
		logic [TimeW:0] s;
		s = {1'b0, a} + {{(TimeW + 1 - FrameW){1'b0}}, b};
		return (s > 17'h0FFFF) ? 16'hFFFF : s[TimeW-1:0];
	endfunction

	// advances the segment state by one frame, returns 1 when an event is due
	function automatic bit track_frame(input logic act, input logic done,
			output seg_event_t ev);
		bit emit;
		emit = 1'b0;
		ev = '0;
		ev.frame = 1'b1;
		if (trk.busy) begin
			if (!done)
				return 1'b0;
			trk.busy = 1'b0;
		end
		if (trk.over_pending) begin
			if (act)
				return 1'b0;
			trk.over_pending = 1'b0;
		end
		if (trk.speaking != act) begin
			if (act) begin
				trk.segment_time = {{(TimeW - FrameW){1'b0}}, shadow_cfg.frame_ms};
				trk.speaking = 1'b1;
				ev.start = 1'b1;
				emit = 1'b1;
			end else if (trk.silence_time >= shadow_cfg.hangover) begin
				trk.segment_time = sat_ms(trk.segment_time, shadow_cfg.frame_ms);
				trk.speaking = 1'b0;
				ev.stop = 1'b1;
				ev.drop = trk.segment_time < shadow_cfg.min_time;
				emit = 1'b1;
			end
		end else if (trk.speaking) begin
			trk.segment_time = sat_ms(trk.segment_time, shadow_cfg.frame_ms);
			if (trk.segment_time >= shadow_cfg.max_ms) begin
				ev.stop = 1'b1;
				ev.over = 1'b1;
				trk.speaking = 1'b0;
				trk.over_pending = 1'b1;
			end
			emit = 1'b1;
		end
		trk.silence_time = act ? '0 : sat_ms(trk.silence_time, shadow_cfg.frame_ms);
		if (emit) begin
			trk.busy = 1'b1;
			ev.dur = trk.segment_time;
		end
		return emit;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
	endtask

	// frame word driver
	always @(posedge clk) begin : frame_driver
		frame_word_t w;
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_frames.size() != 0 && !(idle_on && $urandom_range(0, 99) < 14)) begin
				w = pending_frames.pop_front();
				in_valid <= 1'b1;
				voice_active <= w.act;
				consumer_done <= w.done;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver, with one long hold-off once the run is under way
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_used && frames_taken >= 400) begin
			hold_used <= 1'b1;
			hold_left <= 300;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(0, 99) < 14);
		end
	end

	always @(posedge clk) begin : check_and_track
		seg_event_t seen, want, nxt;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				seen = '{voice_start, voice_frame, voice_stop, voice_over, voice_drop,
					duration_ms};
				if (awaited_events.size() == 0) begin
					flag_mismatch("word with none awaited", seen.dur, 0);
				end else begin
					want = awaited_events.pop_front();
					if (seen.start !== want.start)
						flag_mismatch("voice_start", seen.start, want.start);
					if (seen.frame !== want.frame)
						flag_mismatch("voice_frame", seen.frame, want.frame);
					if (seen.stop !== want.stop)
						flag_mismatch("voice_stop", seen.stop, want.stop);
					if (seen.over !== want.over)
						flag_mismatch("voice_over", seen.over, want.over);
					if (seen.drop !== want.drop)
						flag_mismatch("voice_drop", seen.drop, want.drop);
					if (seen.dur !== want.dur)
						flag_mismatch("duration_ms", seen.dur, want.dur);
				end
			end
			if (in_valid && in_ready) begin
				frames_taken <= frames_taken + 1;
				if (track_frame(voice_active, consumer_done, nxt))
					awaited_events.push_back(nxt);
			end
		end
	end

	task automatic push_frame(input logic act, input logic done);
		pending_frames.push_back('{act, done});
	endtask

	// speech bursts followed by silence, with some noise words mixed in
	task automatic push_bursts(input int n, input int max_on, input int max_off);
		int cnt, len;
		cnt = 0;
		while (cnt < n) begin
			if ($urandom_range(0, 99) < 15) begin
				push_frame($urandom_range(0, 1), $urandom_range(0, 1));
				cnt++;
			end else begin
				len = $urandom_range(1, max_on);
				repeat (len) push_frame(1'b1, $urandom_range(0, 99) < 80);
				cnt += len;
				len = $urandom_range(1, max_off);
				repeat (len) push_frame(1'b0, $urandom_range(0, 99) < 80);
				cnt += len;
			end
		end
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_FRAME_TIME: shadow_cfg.frame_ms = data[FrameW-1:0];
			REG_MAX_TIME:   shadow_cfg.max_ms = data;
			REG_MIN_TIME:   shadow_cfg.min_time = data;
			REG_HANGOVER:   shadow_cfg.hangover = data;
			default: ;
		endcase
	endtask

	task automatic set_regs(input int frame_ms, input int max_ms, input int min_ms,
			input int hang_ms);
		// unused upper bits of the frame time write carry random values
		cfg_write(REG_FRAME_TIME, {11'($urandom_range(0, 2047)), 5'(frame_ms)});
		cfg_write(REG_MAX_TIME, 16'(max_ms));
		cfg_write(REG_MIN_TIME, 16'(min_ms));
		cfg_write(REG_HANGOVER, 16'(hang_ms));
	endtask

	task automatic settle();
		do
			@(posedge clk);
		while (pending_frames.size() != 0 || in_valid || awaited_events.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: ignored done, start, busy discard, hangover, drop
		push_frame(1'b0, 1'b1);
		push_frame(1'b1, 1'b0);
		push_frame(1'b1, 1'b0);
		push_frame(1'b1, 1'b1);
		repeat (5) push_frame(1'b0, 1'b1);
		push_frame(1'b0, 1'b0);
		settle();

		// short segments: over, wait after over, zero hangover stop
		set_regs(10, 40, 30, 0);
		repeat (5) push_frame(1'b1, 1'b1);
		push_frame(1'b0, 1'b1);
		push_frame(1'b1, 1'b1);
		push_frame(1'b0, 1'b1);
		push_frame(1'b1, 1'b0);
		repeat (3) push_frame(1'b1, 1'b1);
		push_frame(1'b0, 1'b1);
		settle();

		set_regs(20, 5000, 300, 100);
		push_bursts(170, 20, 10);
		settle();

		set_regs(10, 200, 60, 30);
		push_bursts(170, 30, 8);
		settle();

		set_regs(31, 0, 65535, 0);
		push_bursts(130, 6, 4);
		settle();

		set_regs(0, 65535, 0, 65535);
		push_bursts(110, 8, 8);
		settle();

		// no idling on either side
		idle_on <= 1'b0;
		set_regs($urandom_range(1, 31), $urandom_range(50, 600), $urandom_range(0, 300),
			$urandom_range(0, 100));
		push_bursts(200, 25, 10);
		settle();
		idle_on <= 1'b1;

		set_regs($urandom_range(0, 31), $urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535));
		push_bursts(130, 25, 10);
		settle();

		// long unbroken runs of speech and of silence
		set_regs(31, 65535, 65535, 65535);
		push_frame(1'b0, 1'b1);
		repeat (60) push_frame(1'b1, $urandom_range(0, 19) != 0);
		push_frame(1'b0, 1'b1);
		push_frame(1'b1, 1'b1);
		repeat (60) push_frame(1'b0, $urandom_range(0, 19) != 0);
		settle();

		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
